// ===== rtl/timed_duplicate_message_filter_core_defines.svh =====
// Assertion macros shared by the duplicate filter RTL.
`ifndef TIMED_DUPLICATE_MESSAGE_FILTER_CORE_DEFINES_SVH
`define TIMED_DUPLICATE_MESSAGE_FILTER_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define TDMF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define TDMF_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/tdmf_pkg.sv =====
// Shared constants and types for the timed duplicate message filter.
`default_nettype none
package tdmf_pkg;

    localparam int HISTORY_DEPTH_DEF = 15;
    localparam int TIME_W            = 48;
    localparam int KEY_W             = 64;
    localparam int WIN_W             = 16;
    localparam int APB_DATA_W        = 32;
    localparam int APB_ADDR_W        = 3;

    localparam logic [WIN_W-1:0] WINDOW_RESET = 16'd600;

    // register index, decoded from paddr[2]
    localparam logic REG_WINDOW = 1'b0;

    // result of one pass through the shared compare unit
    typedef struct packed {
        logic over;   // entry age is greater than the window
        logic match;  // same key, different timestamp
    } cmp_res_t;

endpackage
`default_nettype wire

// ===== rtl/tdmf_hist.sv =====
// History memory: one write port, one registered read port.
`default_nettype none
module tdmf_hist
    import tdmf_pkg::*;
#(
    parameter int DEPTH  = HISTORY_DEPTH_DEF,
    parameter int SLOT_W = 4
)
(
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [SLOT_W-1:0] wr_addr,
    input  wire logic [TIME_W-1:0] wr_time,
    input  wire logic [KEY_W-1:0]  wr_key,
    input  wire logic [SLOT_W-1:0] rd_addr,
    output logic      [TIME_W-1:0] rd_time,
    output logic      [KEY_W-1:0]  rd_key
);

    logic [TIME_W+KEY_W-1:0] mem [DEPTH];
    logic [TIME_W+KEY_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= {wr_key, wr_time};
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_time = rd_data_reg[TIME_W-1:0];
    assign rd_key  = rd_data_reg[TIME_W+KEY_W-1:TIME_W];

endmodule
`default_nettype wire

// ===== rtl/tdmf_cmp.sv =====
// Shared compare unit: age against window, key and timestamp match.
`default_nettype none
module tdmf_cmp
    import tdmf_pkg::*;
(
    input  wire logic [TIME_W-1:0] now_time,
    input  wire logic [KEY_W-1:0]  now_key,
    input  wire logic [WIN_W-1:0]  window,
    input  wire logic [TIME_W-1:0] ent_time,
    input  wire logic [KEY_W-1:0]  ent_key,
    output cmp_res_t               res
);

    logic [TIME_W-1:0] age;

    // age wraps modulo 2^48
    assign age       = now_time - ent_time;
    assign res.over  = age > {{(TIME_W-WIN_W){1'b0}}, window};
    assign res.match = (ent_key == now_key) && (ent_time != now_time);

endmodule
`default_nettype wire

// ===== rtl/timed_duplicate_message_filter_core.sv =====
// Top level of the timed duplicate message filter: sequencer, registers, ports.
//
// Input beats on s_* carry a 48-bit millisecond timestamp and a 64-bit
// message key. Each beat gives one output beat on m_* whose bit 0 says the
// message is a duplicate: an entry with the same key and a different
// timestamp is still in the history after aging.
// Per beat the block drops the oldest entry if the history is full, appends
// the new one, ages out old entries from the oldest end, then scans all
// entries. One history read port and one compare unit are shared by the
// age loop and the scan, which reads every entry left after aging (up to
// HISTORY_DEPTH); s_tready comes back in the same cycle as m_tvalid, so
// a new beat is accepted only once the previous one has been processed.
// A result waits in the output register while the receiver stalls; a new
// beat can then still be accepted, but its result is held until the
// previous one is taken.
// Reset empties the history and sets window_ms to 600. The user must write
// window_ms (APB, byte address 0) only while idle; the block does not check.
`default_nettype none
module timed_duplicate_message_filter_core
    import tdmf_pkg::*;
#(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // stream input
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [111:0]          s_tdata,  // [47:0] timestamp_ms, [111:48] message_key
    // stream output
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [7:0]                 m_tdata,  // [0] is_duplicate, [7:1] zero
    // APB configuration
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

`include "timed_duplicate_message_filter_core_defines.svh"

    localparam int SLOT_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);
    localparam logic [CNT_W-1:0]  DEPTH_C = CNT_W'(HISTORY_DEPTH);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(HISTORY_DEPTH - 1);
    localparam logic [SLOT_W:0]   DEPTH_S = (SLOT_W + 1)'(HISTORY_DEPTH);

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PRD  = 3'd1;
    localparam logic [2:0] S_PCK  = 3'd2;
    localparam logic [2:0] S_SCAN = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
        logic [SLOT_W-1:0] r;
        if (s == LAST_SLOT)
        begin
            r = '0;
        end
        else
        begin
            r = s + 1'b1;
        end
        return r;
    endfunction

    // both operands are below the depth, so one subtract wraps the sum
    function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] a,
                                                   input logic [SLOT_W-1:0] b);
        logic [SLOT_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (sum >= DEPTH_S)
        begin
            sum = sum - DEPTH_S;
        end
        return sum[SLOT_W-1:0];
    endfunction

    logic [2:0]        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [SLOT_W-1:0] oldest_reg, oldest_next;
    logic [SLOT_W-1:0] scan_slot_reg, scan_slot_next;
    logic [CNT_W-1:0]  scan_left_reg, scan_left_next;
    logic              chk_vld_reg, chk_vld_next;
    logic              dup_reg, dup_next;
    logic              out_vld_reg, out_vld_next;
    logic              out_dup_reg, out_dup_next;
    logic [TIME_W-1:0] now_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [WIN_W-1:0]  window_reg;

    logic              accept;
    logic              full;
    logic [SLOT_W-1:0] oldest_acc;
    logic [CNT_W-1:0]  count_acc;
    logic [SLOT_W-1:0] wr_slot;
    logic [SLOT_W-1:0] rd_addr;
    logic [TIME_W-1:0] ent_time;
    logic [KEY_W-1:0]  ent_key;
    cmp_res_t          cmp;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_WINDOW) ?
                    {{(APB_DATA_W-WIN_W){1'b0}}, window_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= WINDOW_RESET;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == REG_WINDOW))
        begin
            window_reg <= pwdata[WIN_W-1:0];
        end
    end

    // slot bookkeeping for the append: drop the oldest first when full
    assign full       = (count_reg == DEPTH_C);
    assign oldest_acc = full ? slot_inc(oldest_reg) : oldest_reg;
    assign count_acc  = full ? (count_reg - 1'b1) : count_reg;
    assign wr_slot    = slot_add(oldest_acc, count_acc[SLOT_W-1:0]);

    // one read port, shared by aging and scanning
    assign rd_addr = (state_reg == S_SCAN) ? scan_slot_reg : oldest_reg;

    tdmf_hist #(
        .DEPTH  (HISTORY_DEPTH),
        .SLOT_W (SLOT_W)
    ) u_hist (
        .clk     (clk),
        .wr_en   (accept),
        .wr_addr (wr_slot),
        .wr_time (s_tdata[TIME_W-1:0]),
        .wr_key  (s_tdata[TIME_W+KEY_W-1:TIME_W]),
        .rd_addr (rd_addr),
        .rd_time (ent_time),
        .rd_key  (ent_key)
    );

    tdmf_cmp u_cmp (
        .now_time (now_reg),
        .now_key  (key_reg),
        .window   (window_reg),
        .ent_time (ent_time),
        .ent_key  (ent_key),
        .res      (cmp)
    );

    // item payload, latched on accept
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            now_reg <= s_tdata[TIME_W-1:0];
            key_reg <= s_tdata[TIME_W+KEY_W-1:TIME_W];
        end
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        oldest_next    = oldest_reg;
        scan_slot_next = scan_slot_reg;
        scan_left_next = scan_left_reg;
        chk_vld_next   = 1'b0;
        dup_next       = dup_reg;
        out_vld_next   = out_vld_reg && !m_tready;
        out_dup_next   = out_dup_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    oldest_next = oldest_acc;
                    count_next  = count_acc + 1'b1;
                    dup_next    = 1'b0;
                    state_next  = S_PRD;
                end
            end
            S_PRD:
            begin
                state_next = S_PCK;
            end
            S_PCK:
            begin
                if (cmp.over && (count_reg != '0))
                begin
                    oldest_next = slot_inc(oldest_reg);
                    count_next  = count_reg - 1'b1;
                    state_next  = S_PRD;
                end
                else
                begin
                    scan_slot_next = oldest_reg;
                    scan_left_next = count_reg;
                    state_next     = S_SCAN;
                end
            end
            S_SCAN:
            begin
                // issue one read and check the one issued in the previous cycle
                if (chk_vld_reg && cmp.match)
                begin
                    dup_next = 1'b1;
                end
                if (scan_left_reg != '0)
                begin
                    scan_slot_next = slot_inc(scan_slot_reg);
                    scan_left_next = scan_left_reg - 1'b1;
                    chk_vld_next   = 1'b1;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_vld_reg || m_tready)
                begin
                    out_vld_next = 1'b1;
                    out_dup_next = dup_reg;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            oldest_reg    <= '0;
            scan_slot_reg <= '0;
            scan_left_reg <= '0;
            chk_vld_reg   <= 1'b0;
            dup_reg       <= 1'b0;
            out_vld_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            oldest_reg    <= oldest_next;
            scan_slot_reg <= scan_slot_next;
            scan_left_reg <= scan_left_next;
            chk_vld_reg   <= chk_vld_next;
            dup_reg       <= dup_next;
            out_vld_reg   <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_dup_reg <= out_dup_next;
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {7'b0, out_dup_reg};

    // checks
    `TDMF_ASSERT_IMP(a_count_in_range, 1'b1, count_reg <= DEPTH_C, "history count exceeds depth")
    `TDMF_ASSERT_IMP(a_oldest_in_range, 1'b1, oldest_reg <= LAST_SLOT, "oldest slot out of range")
    `TDMF_ASSERT_NXT(a_append_nonempty, accept, count_reg != '0, "history empty after append")
    `TDMF_ASSERT_IMP(a_result_from_done, $rose(m_tvalid), $past(state_reg) == S_DONE,
                     "result not from done state")
    `TDMF_ASSERT_IMP(a_scan_never_empty, state_reg == S_SCAN, count_reg != '0,
                     "scan with empty history")

endmodule
`default_nettype wire

// ===== sim/tdmf_verdict_checker.sv =====
// Checker for the duplicate filter: models the message history and compares verdicts.
`default_nettype none
module tdmf_verdict_checker
    import tdmf_pkg::*;
#(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    input  wire logic                  s_tready,
    input  wire logic [111:0]          s_tdata,  // [47:0] timestamp_ms, [111:48] message_key
    input  wire logic                  m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic [7:0]            m_tdata,  // [0] is_duplicate, [7:1] zero
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    input  wire logic [APB_DATA_W-1:0] prdata,
    input  wire logic                  pready,
    output int                         fail_count,
    output int                         verdicts_pending,
    output int                         verdicts_checked,
    output int                         dups_flagged
);

    // modeled history ring and window register
    logic [TIME_W-1:0] seen_time [HISTORY_DEPTH];
    logic [KEY_W-1:0]  seen_key  [HISTORY_DEPTH];
    int unsigned       fill;
    int unsigned       head;
    logic [WIN_W-1:0]  window;
    logic              verdict_q [$];
    logic              want;
    logic              fresh;

    // log a mismatch; only the first ten are printed
    function automatic void flag_mismatch(string what, logic [63:0] exp_val,
                                          logic [63:0] got_val);
        fail_count++;
        if (fail_count <= 10)
            $display("%0t: %s: expected %0h, got %0h", $time, what, exp_val, got_val);
    endfunction

    // store the message, age out the history, and say whether it repeats
    function automatic logic recall_duplicate(logic [TIME_W-1:0] now, logic [KEY_W-1:0] key);
        logic [TIME_W-1:0] age;
        int unsigned       slot;
        logic              hit;
        hit = 1'b0;
        if (fill == HISTORY_DEPTH)
        begin
            head = (head + 1) % HISTORY_DEPTH;
            fill--;
        end
        slot            = (head + fill) % HISTORY_DEPTH;
        seen_time[slot] = now;
        seen_key[slot]  = key;
        fill++;
        // the new entry has age zero, so this always stops at it
        while (fill > 0)
        begin
            age = now - seen_time[head];
            if (age <= window)
                break;
            head = (head + 1) % HISTORY_DEPTH;
            fill--;
        end
        for (int i = 0; i < fill; i++)
        begin
            slot = (head + i) % HISTORY_DEPTH;
            if (seen_key[slot] == key && seen_time[slot] != now)
                hit = 1'b1;
        end
        return hit;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window           = WINDOW_RESET;
            fill             = 0;
            head             = 0;
            verdict_q.delete();
            fail_count       = 0;
            verdicts_pending = 0;
            verdicts_checked = 0;
            dups_flagged     = 0;
        end
        else
        begin
            // register access
            if (psel && penable && pready && paddr[APB_ADDR_W-1:2] == REG_WINDOW)
            begin
                if (pwrite)
                    window = pwdata[WIN_W-1:0];
                else if (prdata !== {{(APB_DATA_W-WIN_W){1'b0}}, window})
                    flag_mismatch("window_ms readback", 64'(window), 64'(prdata));
            end
            // message beat in
            if (s_tvalid && s_tready)
            begin
                fresh     = recall_duplicate(s_tdata[TIME_W-1:0], s_tdata[TIME_W +: KEY_W]);
                verdict_q = {verdict_q, fresh};
            end
            // verdict beat out
            if (m_tvalid && m_tready)
            begin
                if (verdict_q.size() == 0)
                    flag_mismatch("verdict beat with no message pending", 64'd0,
                                  64'(m_tdata));
                else
                begin
                    want = verdict_q.pop_front();
                    verdicts_checked++;
                    if (want)
                        dups_flagged++;
                    if (m_tdata[0] !== want)
                        flag_mismatch("is_duplicate", 64'(want), 64'(m_tdata[0]));
                    if (m_tdata[7:1] !== 7'd0)
                        flag_mismatch("m_tdata pad bits", 64'd0, 64'(m_tdata[7:1]));
                end
            end
            verdicts_pending = verdict_q.size();
        end
    end

endmodule
`default_nettype wire

// ===== sim/tb.sv =====
// Testbench top for the duplicate filter: clock, reset, stimulus and verdict.
`default_nettype none
module tb;
    import tdmf_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 64;
    localparam int IDLE_GAP      = 4;
    localparam int KEY_POOL      = 5;
    localparam logic [APB_ADDR_W-1:0] WINDOW_ADDR = {REG_WINDOW, 2'b00};
    // one slot past the register list; writes there must be ignored
    localparam logic [APB_ADDR_W-1:0] SPARE_ADDR  = {~REG_WINDOW, 2'b00};
    localparam logic [KEY_W-1:0]      FILL_KEY    = 64'h5A5A_0000_0000_0000;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [111:0]          s_tdata  = '0;  // [47:0] timestamp_ms, [111:48] message_key
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [7:0]            m_tdata;        // [0] is_duplicate, [7:1] zero
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int fail_count;
    int verdicts_pending;
    int verdicts_checked;
    int dups_flagged;

    // stimulus state
    logic [TIME_W-1:0] cur_ts = '0;
    int unsigned       cur_win = WINDOW_RESET;
    logic [KEY_W-1:0]  key_pool [KEY_POOL];
    logic              calm = 1'b0;
    int                msgs_sent = 0;
    int                windows_used = 1;
    int                stall_left = 0;
    int                cycles = 0;

    always #5 clk = ~clk;

    timed_duplicate_message_filter_core i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    tdmf_verdict_checker i_check (
        .clk              (clk),
        .rst_n            (rst_n),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .s_tdata          (s_tdata),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .fail_count       (fail_count),
        .verdicts_pending (verdicts_pending),
        .verdicts_checked (verdicts_checked),
        .dups_flagged     (dups_flagged)
    );

    // receiver stalls in random bursts, none once calm
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 7) == 0)
        begin
            stall_left <= $urandom_range(0, 5);
            m_tready   <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("timed_duplicate_message_filter_core: mismatch");
            $finish;
        end
    end

    // one APB transfer, setup then access, then idle; upper write bits are junk
    task automatic apb_access(input logic is_write, input logic [APB_ADDR_W-1:0] addr,
                              input logic [WIN_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= addr;
        pwdata  <= {16'($urandom), value};
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    // one message beat, with an optional sender gap ahead of it
    task automatic send_msg(input logic [TIME_W-1:0] ts, input logic [KEY_W-1:0] key);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {key, ts};
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
        msgs_sent++;
    endtask

    // hold off the sender until every verdict is back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (verdicts_pending != 0)
            @(negedge clk);
    endtask

    // change the window while idle and read it back
    task automatic set_window(input logic [WIN_W-1:0] win);
        wait_drained();
        repeat (IDLE_GAP) @(negedge clk);
        apb_access(1'b1, WINDOW_ADDR, win);
        apb_access(1'b0, WINDOW_ADDR, '0);
        cur_win = win;
        windows_used++;
    endtask

    // random message: mostly small steps and pooled keys so repeats land in the window
    task automatic next_random_msg();
        int unsigned      pick;
        logic [KEY_W-1:0] key;
        pick = $urandom_range(0, 99);
        if (pick >= 97)
            cur_ts = {16'($urandom), $urandom};
        else if (pick >= 92)
            cur_ts -= $urandom_range(1, 20);
        else if (pick >= 80)
            cur_ts += cur_win + $urandom_range(0, 2);
        else if (pick >= 35)
            cur_ts += $urandom_range(1, cur_win / 4 + 1);
        pick = $urandom_range(0, 99);
        if (pick < 75)
            key = key_pool[$urandom_range(0, KEY_POOL - 1)];
        else if (pick < 85)
            key = key_pool[$urandom_range(0, KEY_POOL - 1)] ^ (64'd1 << $urandom_range(0, 63));
        else
            key = {$urandom, $urandom};
        send_msg(cur_ts, key);
    endtask

    task automatic run_phase(input logic [WIN_W-1:0] win, input int count);
        set_window(win);
        for (int k = 0; k < KEY_POOL; k++)
            key_pool[k] = {$urandom, $urandom};
        repeat (count) next_random_msg();
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset window value, then directed cases at window 600
        apb_access(1'b0, WINDOW_ADDR, '0);
        send_msg(48'd0, '0);
        send_msg(48'd0, '0);                    // repeat in the same ms passes
        send_msg(48'd100, '0);                  // repeat inside the window
        send_msg(48'd701, '1);                  // every earlier entry ages out
        send_msg(48'd1301, '1);                 // age exactly the window is kept
        send_msg(48'hFFFF_FFFF_FFF0, '1);
        send_msg(48'd5, '1);                    // timestamp wraps past 2^48
        send_msg(48'd3, '1);                    // timestamp goes backward
        // fill the history, then the oldest key falls off when full
        for (int i = 0; i < HISTORY_DEPTH_DEF; i++)
            send_msg(48'd1000, FILL_KEY + i);
        send_msg(48'd1001, FILL_KEY);

        // window zero keeps only same-ms repeats
        set_window(16'd0);
        send_msg(48'd2000, '0);
        send_msg(48'd2000, '0);
        send_msg(48'd2001, '0);

        // widest window, plus a write outside the register map
        set_window(16'hFFFF);
        apb_access(1'b1, SPARE_ADDR, 16'd0);
        apb_access(1'b0, WINDOW_ADDR, '0);
        cur_ts = 48'd2001 + 48'd65535;
        send_msg(cur_ts, '0);

        // random phases across several windows
        run_phase(16'd5, 240);
        run_phase(16'd0, 240);
        run_phase(16'($urandom_range(1, 3000)), 240);
        run_phase(16'd40, 240);
        run_phase(16'hFFFF, 240);
        calm = 1'b1;
        run_phase(WINDOW_RESET, 200);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("covered %0d messages, %0d verdicts checked, %0d of them duplicates",
                 msgs_sent, verdicts_checked, dups_flagged);
        $display("across %0d window settings incl. 0, 65535 and the reset value",
                 windows_used);
        if (fail_count == 0 && verdicts_pending == 0)
            $display("timed_duplicate_message_filter_core: match");
        else
            $display("timed_duplicate_message_filter_core: mismatch");
        $finish;
    end

endmodule
`default_nettype wire

// ===== files.f =====
+incdir+rtl
rtl/tdmf_pkg.sv
rtl/tdmf_hist.sv
rtl/tdmf_cmp.sv
rtl/timed_duplicate_message_filter_core.sv
sim/tdmf_verdict_checker.sv
sim/tb.sv
